FILE: sv/hs3_pkg.sv
// Shared types, constants and helpers for the 3D heat stencil step core.
// Used by hs3_ctrl, hs3_datapath and heat_stencil_3d_step_core.
`timescale 1ns / 1ps
`default_nettype none
package hs3_pkg;

  localparam int MAX_X     = 64;
  localparam int MAX_Y     = 64;
  localparam int MAX_Z     = 64;
  localparam int SIZE_W    = 7;
  localparam int PLANE_W   = $clog2(MAX_X * MAX_Y + 1);
  localparam int CNT_W     = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
  localparam int WIN_DEPTH = 2 * MAX_X * MAX_Y + 1;
  localparam int SLOT_W    = $clog2(WIN_DEPTH);
  localparam int VAL_W     = 32;
  localparam int COEF_W    = 31;
  localparam int SCALE_W   = 32;
  localparam int CELL_W    = 18;
  localparam int ACC_W     = 48;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd5;

  // neighbour read order
  localparam logic [2:0] RD_CTR = 3'd0;
  localparam logic [2:0] RD_XM  = 3'd1;
  localparam logic [2:0] RD_XP  = 3'd2;
  localparam logic [2:0] RD_YM  = 3'd3;
  localparam logic [2:0] RD_YP  = 3'd4;
  localparam logic [2:0] RD_ZM  = 3'd5;
  localparam logic [2:0] RD_ZP  = 3'd6;

  // flux order: odd entries are low faces and are subtracted
  localparam logic [2:0] FL_XP = 3'd0;
  localparam logic [2:0] FL_XM = 3'd1;
  localparam logic [2:0] FL_YP = 3'd2;
  localparam logic [2:0] FL_YM = 3'd3;
  localparam logic [2:0] FL_ZP = 3'd4;
  localparam logic [2:0] FL_ZM = 3'd5;

  // multiply phases of one flux
  localparam logic [1:0] PH_COEF   = 2'd0;
  localparam logic [1:0] PH_HI     = 2'd1;
  localparam logic [1:0] PH_LO     = 2'd2;
  localparam logic [1:0] PH_LO_ACC = 2'd3;

  localparam logic [STEP_W-1:0] READ_LAST = 5'd7;
  localparam logic [STEP_W-1:0] CALC_LAST = 5'd23;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_CALC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       take;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       cap_en;
    logic [2:0] cap_sel;
    logic       acc_init;
    logic       mul_en;
    logic [2:0] flux_sel;
    logic [1:0] phase;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic can_emit;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [COEF_W-1:0] fx;
    logic [COEF_W-1:0] fy;
    logic [COEF_W-1:0] fz;
  } win_entry_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] r,
                                                   input logic [SIZE_W-1:0] mx);
    logic [SIZE_W-1:0] res;
    res = r;
    if (r == '0) res = SIZE_W'(1);
    else if (r > mx) res = mx;
    return res;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] off);
    logic [SLOT_W:0] t;
    t = {1'b0, s} + {1'b0, off};
    if (t >= (SLOT_W+1)'(WIN_DEPTH)) t = t - (SLOT_W+1)'(WIN_DEPTH);
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] off);
    logic [SLOT_W:0] t;
    if (s >= off) t = {1'b0, s} - {1'b0, off};
    else t = {1'b0, s} + (SLOT_W+1)'(WIN_DEPTH) - {1'b0, off};
    return t[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/heat_stencil_3d_step_core.sv
// A request that emits nothing goes from accept through a check back to ready.
// One that emits also reads the centre and six neighbours (one memory port),
// then 24 multiply steps (one shared 33x33 multiplier, 4 per face flux), then emits.
// The result sits in an output register; the next request is taken meanwhile.
// Synchronous active-low reset clears counters, control and config (sizes 32,
// scales 1.0); the window memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module heat_stencil_3d_step_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [hs3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hs3_pkg::SCALE_W-1:0]       cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_action,
  input  wire logic signed [hs3_pkg::VAL_W-1:0]  in_temperature,
  input  wire logic [hs3_pkg::COEF_W-1:0]        in_face_coef_x,
  input  wire logic [hs3_pkg::COEF_W-1:0]        in_face_coef_y,
  input  wire logic [hs3_pkg::COEF_W-1:0]        in_face_coef_z,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [hs3_pkg::VAL_W-1:0]       out_new_temperature,
  output logic [hs3_pkg::CELL_W-1:0]             out_cell_number,
  output logic                                   out_last_cell
);

  hs3_pkg::cmd_t cmd;
  hs3_pkg::sts_t sts;

  hs3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hs3_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_action           (in_action),
    .in_temperature      (in_temperature),
    .in_face_coef_x      (in_face_coef_x),
    .in_face_coef_y      (in_face_coef_y),
    .in_face_coef_z      (in_face_coef_z),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_new_temperature (out_new_temperature),
    .out_cell_number     (out_cell_number),
    .out_last_cell       (out_last_cell)
  );

endmodule
`default_nettype wire

FILE: sv/hs3_ctrl.sv
// Controller for the heat stencil core: sequences accept, window reads,
// flux multiplies and result hand-off. Depends on hs3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hs3_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire hs3_pkg::sts_t sts,
  output hs3_pkg::cmd_t    cmd
);

  hs3_pkg::state_t                   state_r, state_nxt;
  logic [hs3_pkg::STEP_W-1:0]        step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hs3_pkg::S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    logic [hs3_pkg::STEP_W-1:0] prev;
    prev      = step_r - hs3_pkg::STEP_W'(1);
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      hs3_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = hs3_pkg::S_CHECK;
        end
      end
      hs3_pkg::S_CHECK: begin
        step_nxt = '0;
        if (sts.can_emit) state_nxt = hs3_pkg::S_READ;
        else state_nxt = hs3_pkg::S_IDLE;
      end
      hs3_pkg::S_READ: begin
        // read data lands in the cycle after the address
        if (step_r != hs3_pkg::READ_LAST) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = step_r[2:0];
        end
        if (step_r != '0) begin
          cmd.cap_en  = 1'b1;
          cmd.cap_sel = prev[2:0];
        end
        step_nxt = step_r + hs3_pkg::STEP_W'(1);
        if (step_r == hs3_pkg::READ_LAST) begin
          step_nxt  = '0;
          state_nxt = hs3_pkg::S_CALC;
        end
      end
      hs3_pkg::S_CALC: begin
        cmd.mul_en   = 1'b1;
        cmd.acc_init = (step_r == '0);
        cmd.flux_sel = step_r[4:2];
        cmd.phase    = step_r[1:0];
        step_nxt     = step_r + hs3_pkg::STEP_W'(1);
        if (step_r == hs3_pkg::CALC_LAST) begin
          step_nxt  = '0;
          state_nxt = hs3_pkg::S_EMIT;
        end
      end
      hs3_pkg::S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = hs3_pkg::S_IDLE;
        end
      end
      default: state_nxt = hs3_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/hs3_datapath.sv
// Datapath for the heat stencil core: config registers, cell window memory,
// counters, shared multiplier, accumulator and output register. Uses hs3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hs3_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [hs3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hs3_pkg::SCALE_W-1:0]       cfg_wdata,
  input  wire logic                              in_action,
  input  wire logic signed [hs3_pkg::VAL_W-1:0]  in_temperature,
  input  wire logic [hs3_pkg::COEF_W-1:0]        in_face_coef_x,
  input  wire logic [hs3_pkg::COEF_W-1:0]        in_face_coef_y,
  input  wire logic [hs3_pkg::COEF_W-1:0]        in_face_coef_z,
  input  wire hs3_pkg::cmd_t                     cmd,
  output hs3_pkg::sts_t                          sts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [hs3_pkg::VAL_W-1:0]       out_new_temperature,
  output logic [hs3_pkg::CELL_W-1:0]             out_cell_number,
  output logic                                   out_last_cell
);

  localparam int SW = hs3_pkg::SIZE_W;
  localparam int CW = hs3_pkg::COEF_W;
  localparam int VW = hs3_pkg::VAL_W;
  localparam int NW = hs3_pkg::CNT_W;
  localparam int AW = hs3_pkg::ACC_W;
  localparam int MW = hs3_pkg::MUL_W;
  localparam int PW = hs3_pkg::PROD_W;

  // configuration
  logic [SW-1:0]                  size_x_r, size_y_r, size_z_r;
  logic [hs3_pkg::SCALE_W-1:0]    scale_x_r, scale_y_r, scale_z_r;
  logic                           size_wr;

  assign size_wr = cfg_we && (cfg_index == hs3_pkg::REG_SIZE_X ||
                              cfg_index == hs3_pkg::REG_SIZE_Y ||
                              cfg_index == hs3_pkg::REG_SIZE_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r  <= SW'(32);
      size_y_r  <= SW'(32);
      size_z_r  <= SW'(32);
      scale_x_r <= 32'h0100_0000;
      scale_y_r <= 32'h0100_0000;
      scale_z_r <= 32'h0100_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        hs3_pkg::REG_SIZE_X:  size_x_r  <= cfg_wdata[SW-1:0];
        hs3_pkg::REG_SIZE_Y:  size_y_r  <= cfg_wdata[SW-1:0];
        hs3_pkg::REG_SIZE_Z:  size_z_r  <= cfg_wdata[SW-1:0];
        hs3_pkg::REG_SCALE_X: scale_x_r <= cfg_wdata;
        hs3_pkg::REG_SCALE_Y: scale_y_r <= cfg_wdata;
        hs3_pkg::REG_SCALE_Z: scale_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // grid geometry
  logic [SW-1:0]                 sx, sy, sz;
  logic [2*SW-1:0]               plane_full;
  logic [hs3_pkg::PLANE_W-1:0]   plane;
  logic [NW-1:0]                 total;

  assign sx = hs3_pkg::clamp_size(size_x_r, SW'(hs3_pkg::MAX_X));
  assign sy = hs3_pkg::clamp_size(size_y_r, SW'(hs3_pkg::MAX_Y));
  assign sz = hs3_pkg::clamp_size(size_z_r, SW'(hs3_pkg::MAX_Z));
  assign plane_full = {{SW{1'b0}}, sx} * {{SW{1'b0}}, sy};
  assign plane = plane_full[hs3_pkg::PLANE_W-1:0];
  assign total = NW'(plane) * NW'(sz);

  // counters and window pointers
  logic [NW-1:0]                taken_r, emitted_r;
  logic [hs3_pkg::SLOT_W-1:0]   wr_slot_r, em_slot_r;
  logic [SW-1:0]                ei_r, ej_r, ek_r;
  logic                         drain_r;
  logic                         do_write;
  logic                         grid_done;

  assign do_write  = cmd.take && !in_action && (taken_r < total);
  assign grid_done = (emitted_r + NW'(1)) >= total;

  always_ff @(posedge clk) begin
    if (!rst_n || size_wr) begin
      taken_r   <= '0;
      emitted_r <= '0;
      wr_slot_r <= '0;
      em_slot_r <= '0;
      ei_r      <= '0;
      ej_r      <= '0;
      ek_r      <= '0;
    end else begin
      if (do_write) begin
        taken_r   <= taken_r + NW'(1);
        wr_slot_r <= hs3_pkg::slot_add(wr_slot_r, hs3_pkg::SLOT_W'(1));
      end
      if (cmd.emit) begin
        if (grid_done) begin
          // last cell out: start a fresh grid
          taken_r   <= '0;
          emitted_r <= '0;
          wr_slot_r <= '0;
          em_slot_r <= '0;
          ei_r      <= '0;
          ej_r      <= '0;
          ek_r      <= '0;
        end else begin
          emitted_r <= emitted_r + NW'(1);
          em_slot_r <= hs3_pkg::slot_add(em_slot_r, hs3_pkg::SLOT_W'(1));
          if (ei_r + SW'(1) == sx) begin
            ei_r <= '0;
            if (ej_r + SW'(1) == sy) begin
              ej_r <= '0;
              ek_r <= ek_r + SW'(1);
            end else begin
              ej_r <= ej_r + SW'(1);
            end
          end else begin
            ei_r <= ei_r + SW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) drain_r <= in_action;
  end

  assign sts.can_emit = (emitted_r < taken_r) &&
                        ((emitted_r + NW'(plane) < taken_r) ||
                         (drain_r && taken_r >= total));
  assign sts.out_busy = out_valid && !out_ready;

  // cell window memory
  hs3_pkg::win_entry_t           win_mem [hs3_pkg::WIN_DEPTH];
  hs3_pkg::win_entry_t           rdata_r;
  logic [hs3_pkg::SLOT_W-1:0]    rd_addr;
  logic [hs3_pkg::SLOT_W-1:0]    off_x, off_p;

  assign off_x = hs3_pkg::SLOT_W'(sx);
  assign off_p = hs3_pkg::SLOT_W'(plane);

  always_comb begin
    case (cmd.rd_sel)
      hs3_pkg::RD_CTR: rd_addr = em_slot_r;
      hs3_pkg::RD_XM:  rd_addr = hs3_pkg::slot_sub(em_slot_r, hs3_pkg::SLOT_W'(1));
      hs3_pkg::RD_XP:  rd_addr = hs3_pkg::slot_add(em_slot_r, hs3_pkg::SLOT_W'(1));
      hs3_pkg::RD_YM:  rd_addr = hs3_pkg::slot_sub(em_slot_r, off_x);
      hs3_pkg::RD_YP:  rd_addr = hs3_pkg::slot_add(em_slot_r, off_x);
      hs3_pkg::RD_ZM:  rd_addr = hs3_pkg::slot_sub(em_slot_r, off_p);
      hs3_pkg::RD_ZP:  rd_addr = hs3_pkg::slot_add(em_slot_r, off_p);
      default:         rd_addr = em_slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      win_mem[wr_slot_r] <= '{value: in_temperature, fx: in_face_coef_x,
                             fy: in_face_coef_y, fz: in_face_coef_z};
    end
    if (cmd.rd_en) rdata_r <= win_mem[rd_addr];
  end

  // neighbour capture
  logic [VW-1:0] u_r, v_xm_r, v_xp_r, v_ym_r, v_yp_r, v_zm_r, v_zp_r;
  logic [CW-1:0] ax_r, ay_r, az_r, c_xm_r, c_ym_r, c_zm_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        hs3_pkg::RD_CTR: begin
          u_r  <= rdata_r.value;
          ax_r <= rdata_r.fx;
          ay_r <= rdata_r.fy;
          az_r <= rdata_r.fz;
        end
        hs3_pkg::RD_XM: begin
          v_xm_r <= rdata_r.value;
          c_xm_r <= rdata_r.fx;
        end
        hs3_pkg::RD_XP: v_xp_r <= rdata_r.value;
        hs3_pkg::RD_YM: begin
          v_ym_r <= rdata_r.value;
          c_ym_r <= rdata_r.fy;
        end
        hs3_pkg::RD_YP: v_yp_r <= rdata_r.value;
        hs3_pkg::RD_ZM: begin
          v_zm_r <= rdata_r.value;
          c_zm_r <= rdata_r.fz;
        end
        hs3_pkg::RD_ZP: v_zp_r <= rdata_r.value;
        default: ;
      endcase
    end
  end

  // flux operand selection; outside the grid a neighbour reads as zero
  logic              at_xlo, at_xhi, at_ylo, at_yhi, at_zlo, at_zhi;
  logic [VW:0]       u_ext;
  logic [CW-1:0]     f_coef;
  logic [VW:0]       f_diff;
  logic [hs3_pkg::SCALE_W-1:0] f_scale;

  assign at_xlo = (ei_r == '0);
  assign at_ylo = (ej_r == '0);
  assign at_zlo = (ek_r == '0);
  assign at_xhi = (ei_r + SW'(1) == sx);
  assign at_yhi = (ej_r + SW'(1) == sy);
  assign at_zhi = (ek_r + SW'(1) == sz);
  assign u_ext  = {u_r[VW-1], u_r};

  always_comb begin
    f_coef  = ax_r;
    f_diff  = u_ext;
    f_scale = scale_x_r;
    case (cmd.flux_sel)
      hs3_pkg::FL_XP: begin
        f_coef = ax_r;
        f_diff = (at_xhi ? '0 : {v_xp_r[VW-1], v_xp_r}) - u_ext;
      end
      hs3_pkg::FL_XM: begin
        f_coef = at_xlo ? ax_r : c_xm_r;
        f_diff = at_xlo ? u_ext : u_ext - {v_xm_r[VW-1], v_xm_r};
      end
      hs3_pkg::FL_YP: begin
        f_coef  = ay_r;
        f_diff  = (at_yhi ? '0 : {v_yp_r[VW-1], v_yp_r}) - u_ext;
        f_scale = scale_y_r;
      end
      hs3_pkg::FL_YM: begin
        f_coef  = at_ylo ? ay_r : c_ym_r;
        f_diff  = at_ylo ? u_ext : u_ext - {v_ym_r[VW-1], v_ym_r};
        f_scale = scale_y_r;
      end
      hs3_pkg::FL_ZP: begin
        f_coef  = az_r;
        f_diff  = (at_zhi ? '0 : {v_zp_r[VW-1], v_zp_r}) - u_ext;
        f_scale = scale_z_r;
      end
      hs3_pkg::FL_ZM: begin
        f_coef  = at_zlo ? az_r : c_zm_r;
        f_diff  = at_zlo ? u_ext : u_ext - {v_zm_r[VW-1], v_zm_r};
        f_scale = scale_z_r;
      end
      default: ;
    endcase
  end

  // shared signed multiplier: coef*diff, then hi*scale, then lo*scale
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_r;
  logic [23:0]          lo_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] term;

  always_comb begin
    mul_a = $signed({2'b00, f_coef});
    mul_b = $signed(f_diff);
    case (cmd.phase)
      hs3_pkg::PH_COEF: begin
        mul_a = $signed({2'b00, f_coef});
        mul_b = $signed(f_diff);
      end
      hs3_pkg::PH_HI: begin
        // floor of product >> 28, then >> 24: top bits of the product
        mul_a = $signed({{(MW-14){prod_r[PW-1]}}, prod_r[PW-1:52]});
        mul_b = $signed({1'b0, f_scale});
      end
      hs3_pkg::PH_LO: begin
        mul_a = $signed({{(MW-24){1'b0}}, lo_r});
        mul_b = $signed({1'b0, f_scale});
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.phase == hs3_pkg::PH_LO) term = prod_r[AW-1:0];
    else term = $signed({{(AW-(PW-24)){prod_r[PW-1]}}, prod_r[PW-1:24]});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
      if (cmd.phase == hs3_pkg::PH_HI) lo_r <= prod_r[51:28];
      if (cmd.acc_init) begin
        acc_r <= $signed({{(AW-VW){u_r[VW-1]}}, u_r});
      end else if (cmd.phase == hs3_pkg::PH_LO || cmd.phase == hs3_pkg::PH_LO_ACC) begin
        if (cmd.flux_sel[0]) acc_r <= acc_r - term;
        else acc_r <= acc_r + term;
      end
    end
  end

  // output register with saturation
  logic                out_valid_r;
  logic [VW-1:0]       out_temp_r;
  logic [hs3_pkg::CELL_W-1:0] out_cell_r;
  logic                out_last_r;
  logic [VW-1:0]       sat_val;

  always_comb begin
    if (acc_r > $signed(AW'(32'h7FFF_FFFF))) sat_val = 32'h7FFF_FFFF;
    else if (acc_r < -$signed(AW'(33'h0_8000_0000))) sat_val = 32'h8000_0000;
    else sat_val = acc_r[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_temp_r <= sat_val;
      out_cell_r <= emitted_r[hs3_pkg::CELL_W-1:0];
      out_last_r <= grid_done;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_new_temperature = out_temp_r;
  assign out_cell_number     = out_cell_r;
  assign out_last_cell       = out_last_r;

endmodule
`default_nettype wire

FILE: sv/hs3_checker.sv
// Port-level checks for heat_stencil_3d_step_core, attached by bind.
// Depends on hs3_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none
module hs3_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              cfg_we,
  input wire logic [hs3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire logic [hs3_pkg::SCALE_W-1:0]       cfg_wdata,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              in_action,
  input wire logic signed [hs3_pkg::VAL_W-1:0]  in_temperature,
  input wire logic [hs3_pkg::COEF_W-1:0]        in_face_coef_x,
  input wire logic [hs3_pkg::COEF_W-1:0]        in_face_coef_y,
  input wire logic [hs3_pkg::COEF_W-1:0]        in_face_coef_z,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [hs3_pkg::VAL_W-1:0]  out_new_temperature,
  input wire logic [hs3_pkg::CELL_W-1:0]        out_cell_number,
  input wire logic                              out_last_cell
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_temperature) &&
    $stable(out_cell_number) && $stable(out_last_cell))
    else $error("result changed while stalled");

  // one request at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a new result needs work in progress: in_ready is low just before it rises
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work in progress");

endmodule

bind heat_stencil_3d_step_core hs3_checker u_hs3_checker (.*);
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for heat_stencil_3d_step_core: streams 3D grids, predicts
// each updated cell in a local fixed-point model and compares the outputs.
// Depends on hs3_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int WDEPTH = hs3_pkg::WIN_DEPTH;
  localparam int WATCH_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] temp;
    logic [17:0] cell_no;
    logic        last;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [hs3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hs3_pkg::SCALE_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic signed [hs3_pkg::VAL_W-1:0] in_temperature = '0;
  logic [hs3_pkg::COEF_W-1:0] in_face_coef_x = '0;
  logic [hs3_pkg::COEF_W-1:0] in_face_coef_y = '0;
  logic [hs3_pkg::COEF_W-1:0] in_face_coef_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [hs3_pkg::VAL_W-1:0] out_new_temperature;
  logic [hs3_pkg::CELL_W-1:0] out_cell_number;
  logic out_last_cell;

  heat_stencil_3d_step_core DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [31:0] val_win [WDEPTH];
  logic [30:0] fx_win [WDEPTH];
  logic [30:0] fy_win [WDEPTH];
  logic [30:0] fz_win [WDEPTH];
  int unsigned taken_cnt, emitted_cnt;
  int unsigned sz_x = 32, sz_y = 32, sz_z = 32;
  logic [31:0] sc_x = 32'h0100_0000, sc_y = 32'h0100_0000, sc_z = 32'h0100_0000;
  cell_result_t pending_cells[$];
  int errors = 0;
  int idle_pct = 38;
  bit hold_out = 1'b0;
  int stall_cnt = 0;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint face_flux(logic [30:0] c, longint d, logic [31:0] s);
    longint p, hi, lo;
    p = floor_sh(longint'({33'd0, c}) * d, 28);
    hi = floor_sh(p, 24);
    lo = p - hi * 64'sh100_0000;
    return hi * longint'({32'd0, s}) + floor_sh(lo * longint'({32'd0, s}), 24);
  endfunction

  function automatic int unsigned clampsz(int unsigned r, int unsigned mx);
    if (r < 1) return 1;
    if (r > mx) return mx;
    return r;
  endfunction

  function automatic longint cell_val(int unsigned idx);
    return longint'($signed(val_win[idx % WDEPTH]));
  endfunction

  // apply one accepted request to the model and queue any updated cell
  task automatic predict_cell_update(bit drain, logic [31:0] t, logic [30:0] cx,
                                     logic [30:0] cy, logic [30:0] cz);
    int unsigned sx, sy, sz, pl, tot, e, i, j, k, sl;
    longint u, nb, acc;
    cell_result_t r;
    sx = clampsz(sz_x, hs3_pkg::MAX_X);
    sy = clampsz(sz_y, hs3_pkg::MAX_Y);
    sz = clampsz(sz_z, hs3_pkg::MAX_Z);
    pl = sx * sy; tot = pl * sz;
    if (!drain && taken_cnt < tot) begin
      sl = taken_cnt % WDEPTH;
      val_win[sl] = t; fx_win[sl] = cx; fy_win[sl] = cy; fz_win[sl] = cz;
      taken_cnt++;
    end
    if (!(emitted_cnt < taken_cnt &&
          (emitted_cnt + pl < taken_cnt || (drain && taken_cnt >= tot)))) return;
    e = emitted_cnt;
    i = e % sx; j = (e / sx) % sy; k = e / pl; sl = e % WDEPTH;
    u = cell_val(e);
    acc = u;
    nb = (i + 1 < sx) ? cell_val(e + 1) : 0;
    acc += face_flux(fx_win[sl], nb - u, sc_x);
    if (i > 0) acc -= face_flux(fx_win[(e - 1) % WDEPTH], u - cell_val(e - 1), sc_x);
    else acc -= face_flux(fx_win[sl], u, sc_x);
    nb = (j + 1 < sy) ? cell_val(e + sx) : 0;
    acc += face_flux(fy_win[sl], nb - u, sc_y);
    if (j > 0) acc -= face_flux(fy_win[(e - sx) % WDEPTH], u - cell_val(e - sx), sc_y);
    else acc -= face_flux(fy_win[sl], u, sc_y);
    nb = (k + 1 < sz) ? cell_val(e + pl) : 0;
    acc += face_flux(fz_win[sl], nb - u, sc_z);
    if (k > 0) acc -= face_flux(fz_win[(e - pl) % WDEPTH], u - cell_val(e - pl), sc_z);
    else acc -= face_flux(fz_win[sl], u, sc_z);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    r.temp = acc[31:0];
    r.cell_no = e[17:0];
    r.last = (e + 1 == tot);
    pending_cells.push_back(r);
    emitted_cnt++;
    if (emitted_cnt >= tot) begin
      emitted_cnt = 0;
      taken_cnt = 0;
    end
  endtask

  task automatic send_request(bit drain, logic [31:0] t, logic [30:0] cx,
                              logic [30:0] cy, logic [30:0] cz);
    // valid drops between requests; the core never takes two in a row
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_action <= drain;
    in_temperature <= t;
    in_face_coef_x <= cx; in_face_coef_y <= cy; in_face_coef_z <= cz;
    do @(posedge clk); while (!in_ready);
    predict_cell_update(drain, t, cx, cy, cz);
    in_valid <= 1'b0;
  endtask

  task automatic send_cell(logic [31:0] t, logic [30:0] cx, logic [30:0] cy,
                           logic [30:0] cz);
    send_request(1'b0, t, cx, cy, cz);
  endtask

  task automatic send_drain();
    send_request(1'b1, $urandom, 31'($urandom), 31'($urandom), 31'($urandom));
  endtask

  task automatic wait_idle();
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [hs3_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hs3_pkg::REG_SIZE_X: begin sz_x = v[6:0]; taken_cnt = 0; emitted_cnt = 0; end
      hs3_pkg::REG_SIZE_Y: begin sz_y = v[6:0]; taken_cnt = 0; emitted_cnt = 0; end
      hs3_pkg::REG_SIZE_Z: begin sz_z = v[6:0]; taken_cnt = 0; emitted_cnt = 0; end
      hs3_pkg::REG_SCALE_X: sc_x = v;
      hs3_pkg::REG_SCALE_Y: sc_y = v;
      hs3_pkg::REG_SCALE_Z: sc_z = v;
      default: ;
    endcase
  endtask

  task automatic set_grid(int x, int y, int z, logic [31:0] a, logic [31:0] b,
                          logic [31:0] c);
    wait_idle();
    write_reg(hs3_pkg::REG_SIZE_X, 32'(x));
    write_reg(hs3_pkg::REG_SIZE_Y, 32'(y));
    write_reg(hs3_pkg::REG_SIZE_Z, 32'(z));
    write_reg(hs3_pkg::REG_SCALE_X, a);
    write_reg(hs3_pkg::REG_SCALE_Y, b);
    write_reg(hs3_pkg::REG_SCALE_Z, c);
  endtask

  function automatic int unsigned grid_cells();
    return clampsz(sz_x, hs3_pkg::MAX_X) * clampsz(sz_y, hs3_pkg::MAX_Y) *
           clampsz(sz_z, hs3_pkg::MAX_Z);
  endfunction

  // small values keep fluxes in range; full-range values hit saturation
  function automatic logic [31:0] rand_temp(bit wide);
    if (wide) return $urandom;
    return $urandom_range(32'h2000_0000) - 32'h1000_0000;
  endfunction

  function automatic logic [30:0] rand_coef(bit wide);
    if (wide) return 31'($urandom);
    return 31'($urandom_range(32'h0400_0000));
  endfunction

  task automatic run_grid(bit wide, bit extra);
    int unsigned n;
    n = grid_cells();
    for (int c = 0; c < n; c++) begin
      if (extra && $urandom_range(9) == 0) send_drain();
      send_cell(rand_temp(wide), rand_coef(wide), rand_coef(wide), rand_coef(wide));
    end
    if (extra) send_cell($urandom, 31'($urandom), 31'($urandom), 31'($urandom));
    while (pending_cells.size() != 0 || taken_cnt != 0) send_drain();
    if (extra) send_drain();
  endtask

  task automatic test_directed_extremes();
    set_grid(2, 2, 2, 32'h0100_0000, 32'hFFFF_FFFF, 32'h0);
    send_drain();
    send_cell(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_cell(32'h8000_0000, 31'h7FFF_FFFF, 31'h0, 31'h7FFF_FFFF);
    send_drain();
    send_cell(32'h0, 31'h0, 31'h7FFF_FFFF, 31'h0);
    send_cell(32'hFFFF_FFFF, 31'h1, 31'h1, 31'h1);
    send_cell(32'h1000_0000, 31'h1000_0000, 31'h1000_0000, 31'h1000_0000);
    send_cell(32'hF000_0000, 31'h5555_5555, 31'h2AAA_AAAA, 31'h0);
    send_cell(32'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555, 31'h7FFF_FFFF);
    send_cell(32'hAAAA_AAAA, 31'h0, 31'h0, 31'h0);
    send_cell(32'h1234_5678, 31'h1, 31'h2, 31'h3); // surplus, dropped
    repeat (5) send_drain();
  endtask

  task automatic test_size_clamp();
    set_grid(0, 0, 0, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000);
    run_grid(1'b1, 1'b1);
    set_grid(127, 1, 1, 32'h0010_0000, 32'h0100_0000, 32'h0200_0000);
    run_grid(1'b0, 1'b0);
    set_grid(1, 64, 1, 32'h0040_0000, 32'h0010_0000, 32'h0100_0000);
    run_grid(1'b0, 1'b0);
  endtask

  task automatic test_abort_mid_grid();
    set_grid(3, 3, 3, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
    for (int c = 0; c < 13; c++)
      send_cell(rand_temp(1'b0), rand_coef(1'b0), rand_coef(1'b0), 31'h0);
    wait_idle();
    write_reg(hs3_pkg::REG_SIZE_Z, 32'd2);
    run_grid(1'b0, 1'b0);
  endtask

  task automatic test_backpressure();
    set_grid(4, 3, 3, 32'h0100_0000, 32'h0200_0000, 32'h0080_0000);
    idle_pct = 0;
    hold_out = 1'b1;
    run_grid(1'b0, 1'b0);
    idle_pct = 38;
  endtask

  task automatic test_random_grids();
    int phase;
    phase = 0;
    while (phase < 28) begin
      set_grid($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(1, 4),
               $urandom, $urandom_range(32'h0200_0000), $urandom_range(32'h0200_0000));
      idle_pct = (phase >= 16 && phase < 22) ? 0 : 38;
      run_grid($urandom_range(3) == 0, 1'($urandom_range(1)));
      phase++;
    end
    idle_pct = 38;
  endtask

  // receiver stall control
  always @(posedge clk) begin
    if (hold_out) begin
      out_ready <= 1'b0;
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= 300) hold_out <= 1'b0;
    end else begin
      out_ready <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= idle_pct);
    end
  end

  // check each updated cell against the oldest prediction
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        $error("unexpected result cell %0d", out_cell_number);
        errors++;
      end else begin
        want = pending_cells.pop_front();
        if (out_new_temperature !== want.temp) begin
          $error("new_temperature exp %h got %h", want.temp, out_new_temperature);
          errors++;
        end
        if (out_cell_number !== want.cell_no) begin
          $error("cell_number exp %0d got %0d", want.cell_no, out_cell_number);
          errors++;
        end
        if (out_last_cell !== want.last) begin
          $error("last_cell exp %0d got %0d", want.last, out_last_cell);
          errors++;
        end
      end
    end
  end

  // abort on a stuck interface
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("heat_stencil_3d_step_core verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_size_clamp();
    test_abort_mid_grid();
    test_backpressure();
    test_random_grids();
    wait_idle();
    if (pending_cells.size() != 0) errors++;
    if (errors == 0) begin
      $display("heat_stencil_3d_step_core verification clean");
    end else begin
      $display("heat_stencil_3d_step_core verification failed");
    end
    $finish;
  end
endmodule
